/* src/dthc_pkg.sv */
// Shared types and constants for the depth-to-hue colorizer.
// No dependencies; imported by dthc_div and depth_to_hue_colorizer_core.
package dthc_pkg;

  localparam int unsigned DEPTH_W = 16;
  localparam int unsigned CH_W    = 8;

  // Per-item side flags that ride along the divider pipeline.
  typedef struct packed {
    logic blank;  // sample had no measurement: pixel is black
    logic flat;   // empty or inverted range: hue position forced to zero
  } tag_t;

endpackage

/* src/dthc_div.sv */
// Pipelined restoring divider, one quotient bit per stage, for the hue position.
// Depends on dthc_pkg (DEPTH_W, tag_t).
module dthc_div #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic [dthc_pkg::DEPTH_W-1:0]      in_diff,
  input  logic [dthc_pkg::DEPTH_W-1:0]      in_span,
  input  dthc_pkg::tag_t                    in_tag,
  output logic                              in_ready,
  output logic                              out_valid,
  output logic [FRACTION_BITS+2:0]          out_quot,
  output dthc_pkg::tag_t                    out_tag,
  input  logic                              out_ready
);
  import dthc_pkg::*;

  // Quotient covers 0 .. 4.0 with FRACTION_BITS fraction bits.
  localparam int unsigned QW = FRACTION_BITS + 3;

  logic [QW-1:0]      v_r;
  logic [DEPTH_W-1:0] rem_r  [QW];
  logic [DEPTH_W-1:0] span_r [QW];
  logic [QW-1:0]      quot_r [QW];
  tag_t               tag_r  [QW];

  logic [QW:0]        rdy;
  logic [QW-1:0]      prev_v;
  logic [DEPTH_W-1:0] prev_rem  [QW];
  logic [DEPTH_W-1:0] prev_span [QW];
  logic [QW-1:0]      prev_quot [QW];
  tag_t               prev_tag  [QW];
  logic [DEPTH_W:0]   trial     [QW];
  logic [QW-1:0]      qbit;
  logic [DEPTH_W-1:0] rem_nxt   [QW];
  logic [QW-1:0]      quot_nxt  [QW];

  // Ready chain: a stage may load when it is empty or its contents move on.
  always_comb begin
    rdy[QW] = out_ready;
    for (int k = QW - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        prev_v[k]    = in_valid;
        prev_rem[k]  = in_diff;
        prev_span[k] = in_span;
        prev_quot[k] = '0;
        prev_tag[k]  = in_tag;
        // First step: remainder starts at the difference itself.
        trial[k]     = {1'b0, in_diff};
      end else begin
        prev_v[k]    = v_r[k-1];
        prev_rem[k]  = rem_r[k-1];
        prev_span[k] = span_r[k-1];
        prev_quot[k] = quot_r[k-1];
        prev_tag[k]  = tag_r[k-1];
        trial[k]     = {rem_r[k-1], 1'b0};
      end
      qbit[k]     = (trial[k] >= {1'b0, prev_span[k]});
      rem_nxt[k]  = qbit[k] ? DEPTH_W'(trial[k] - {1'b0, prev_span[k]})
                            : trial[k][DEPTH_W-1:0];
      quot_nxt[k] = {prev_quot[k][QW-2:0], qbit[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < QW; k++) begin
        if (rdy[k]) begin
          v_r[k] <= prev_v[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QW; k++) begin
      if (rdy[k] && prev_v[k]) begin
        rem_r[k]  <= rem_nxt[k];
        span_r[k] <= prev_span[k];
        quot_r[k] <= quot_nxt[k];
        tag_r[k]  <= prev_tag[k];
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[QW-1];
  assign out_quot  = quot_r[QW-1];
  assign out_tag   = tag_r[QW-1];

endmodule

/* src/depth_to_hue_colorizer_core.sv */
// Depth-to-hue colorizer: maps 16-bit depth samples to RGBA pixels.
// Stages: the clamp stage, one divider stage per quotient bit, scale and output.
// Throughput: one item per cycle; stages hold on out_stall and empty slots close up.
// Reset (synchronous, rst_n low): pipeline emptied, near_limit = 500, far_limit = 4000.
// Depends on dthc_pkg and dthc_div.
module depth_to_hue_colorizer_core #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration write port
  input  logic                          cfg_wr_en,
  input  logic                          cfg_index,
  input  logic [dthc_pkg::DEPTH_W-1:0]  cfg_wdata,
  // depth sample in
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [dthc_pkg::DEPTH_W-1:0]  in_depth_sample,
  // pixel out
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dthc_pkg::CH_W-1:0]     out_red_level,
  output logic [dthc_pkg::CH_W-1:0]     out_green_level,
  output logic [dthc_pkg::CH_W-1:0]     out_blue_level,
  output logic [dthc_pkg::CH_W-1:0]     out_alpha_level
);
  import dthc_pkg::*;

  localparam int unsigned QW = FRACTION_BITS + 3;

  // Register indexes.
  localparam logic CFG_NEAR = 1'b0;
  localparam logic CFG_FAR  = 1'b1;

  localparam logic [DEPTH_W-1:0] NEAR_RESET = 16'd500;
  localparam logic [DEPTH_W-1:0] FAR_RESET  = 16'd4000;

  // Hue sectors: integer part of the position.
  localparam logic [2:0] SECT_RED_TO_YEL  = 3'd0;
  localparam logic [2:0] SECT_YEL_TO_GRN  = 3'd1;
  localparam logic [2:0] SECT_GRN_TO_CYAN = 3'd2;
  localparam logic [2:0] SECT_CYAN_TO_BLU = 3'd3;

  localparam logic [CH_W-1:0] CH_FULL = 8'hFF;
  localparam logic [CH_W-1:0] CH_NONE = 8'h00;

  // Largest legal position: exactly 4.0.
  localparam logic [QW-1:0] P_MAX = {3'b100, {FRACTION_BITS{1'b0}}};

  // ---------------------------------------------------------------------------
  // Configuration registers. To be written by the user only while the pipeline is
  // idle, so the clamp stage may read them directly; the block does not enforce it.
  // ---------------------------------------------------------------------------
  logic [DEPTH_W-1:0] near_r;
  logic [DEPTH_W-1:0] far_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_r <= NEAR_RESET;
      far_r  <= FAR_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_NEAR: near_r <= cfg_wdata;
        CFG_FAR:  far_r  <= cfg_wdata;
        default:  ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Ready chain from the output back. Each stage advances when it is empty or
  // its item moves on, so bubbles close up while the output is stalled.
  // ---------------------------------------------------------------------------
  logic out_valid_r;
  logic scl_v_r;
  logic clp_v_r;
  logic out_ready;
  logic scl_ready;
  logic div_ready;
  logic clp_ready;

  assign out_ready = !out_valid_r || !out_stall;
  assign scl_ready = !scl_v_r || out_ready;
  assign clp_ready = !clp_v_r || div_ready;
  assign in_stall  = !clp_ready;

  // ---------------------------------------------------------------------------
  // Stage 1: clamp. Clamp to far first, then to near, so near wins on an
  // inverted range (the result is unused then anyway).
  // ---------------------------------------------------------------------------
  logic [DEPTH_W-1:0] clamp_hi;
  logic [DEPTH_W-1:0] clamp_val;
  logic [DEPTH_W-1:0] clp_diff_nxt;
  logic [DEPTH_W-1:0] clp_span_nxt;
  tag_t               clp_tag_nxt;
  logic [DEPTH_W-1:0] clp_diff_r;
  logic [DEPTH_W-1:0] clp_span_r;
  tag_t               clp_tag_r;

  always_comb begin
    clamp_hi          = (in_depth_sample > far_r) ? far_r : in_depth_sample;
    clamp_val         = (clamp_hi < near_r) ? near_r : clamp_hi;
    clp_diff_nxt      = far_r - clamp_val;
    clp_span_nxt      = far_r - near_r;
    clp_tag_nxt.blank = (in_depth_sample == '0);
    clp_tag_nxt.flat  = !(far_r > near_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clp_v_r <= 1'b0;
    end else if (clp_ready) begin
      clp_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (clp_ready && in_valid) begin
      clp_diff_r <= clp_diff_nxt;
      clp_span_r <= clp_span_nxt;
      clp_tag_r  <= clp_tag_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 2 .. QW+1: position p = 4 * diff / span, one quotient bit a stage.
  // ---------------------------------------------------------------------------
  logic          div_valid;
  logic [QW-1:0] div_quot;
  tag_t          div_tag;

  dthc_div #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (clp_v_r),
    .in_diff   (clp_diff_r),
    .in_span   (clp_span_r),
    .in_tag    (clp_tag_r),
    .in_ready  (div_ready),
    .out_valid (div_valid),
    .out_quot  (div_quot),
    .out_tag   (div_tag),
    .out_ready (scl_ready)
  );

  // ---------------------------------------------------------------------------
  // Scale stage: split p into sector and fraction, and form 255*f and
  // 255*(1-f) truncated. Times 255 is a shift and a subtract.
  // ---------------------------------------------------------------------------
  logic [QW-1:0]              pos;
  logic [FRACTION_BITS-1:0]   frac;
  logic [FRACTION_BITS:0]     one_minus;
  logic [FRACTION_BITS+7:0]   up_prod;
  logic [FRACTION_BITS+8:0]   down_prod;
  logic [2:0]                 scl_sector_r;
  logic [CH_W-1:0]            scl_up_r;
  logic [CH_W-1:0]            scl_down_r;
  logic                       scl_blank_r;

  always_comb begin
    // Empty or inverted range: force the position to zero (red).
    pos       = div_tag.flat ? '0 : div_quot;
    frac      = pos[FRACTION_BITS-1:0];
    one_minus = {1'b1, {FRACTION_BITS{1'b0}}} - {1'b0, frac};
    up_prod   = {frac, 8'h00} - {8'h00, frac};
    down_prod = {one_minus, 8'h00} - {8'h00, one_minus};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scl_v_r <= 1'b0;
    end else if (scl_ready) begin
      scl_v_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (scl_ready && div_valid) begin
      scl_sector_r <= pos[QW-1:FRACTION_BITS];
      scl_up_r     <= up_prod[FRACTION_BITS+7:FRACTION_BITS];
      scl_down_r   <= down_prod[FRACTION_BITS+7:FRACTION_BITS];
      scl_blank_r  <= div_tag.blank;
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: pick the channel pattern of the sector; black for a sample
  // without measurement. Sector four (exactly blue) takes the default arm.
  // ---------------------------------------------------------------------------
  logic [CH_W-1:0] red_nxt;
  logic [CH_W-1:0] green_nxt;
  logic [CH_W-1:0] blue_nxt;
  logic [CH_W-1:0] red_r;
  logic [CH_W-1:0] green_r;
  logic [CH_W-1:0] blue_r;

  always_comb begin
    case (scl_sector_r)
      SECT_RED_TO_YEL: begin
        red_nxt = CH_FULL;    green_nxt = scl_up_r;   blue_nxt = CH_NONE;
      end
      SECT_YEL_TO_GRN: begin
        red_nxt = scl_down_r; green_nxt = CH_FULL;    blue_nxt = CH_NONE;
      end
      SECT_GRN_TO_CYAN: begin
        red_nxt = CH_NONE;    green_nxt = CH_FULL;    blue_nxt = scl_up_r;
      end
      SECT_CYAN_TO_BLU: begin
        red_nxt = CH_NONE;    green_nxt = scl_down_r; blue_nxt = CH_FULL;
      end
      default: begin
        red_nxt = scl_up_r;   green_nxt = CH_NONE;    blue_nxt = CH_FULL;
      end
    endcase
    if (scl_blank_r) begin
      red_nxt   = CH_NONE;
      green_nxt = CH_NONE;
      blue_nxt  = CH_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= scl_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && scl_v_r) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_red_level   = red_r;
  assign out_green_level = green_r;
  assign out_blue_level  = blue_r;
  assign out_alpha_level = CH_FULL;

`ifndef ASSERT_OFF
  // A free output must free the whole pipe back to the input.
  a_no_back_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output is free");

  // An accepted item lands in the clamp stage.
  a_take_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> clp_v_r)
    else $error("accepted item lost at clamp stage");

  // The divider never yields a position above 4.0 on a proper range.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (div_valid && !div_tag.flat) |-> (div_quot <= P_MAX))
    else $error("hue position above four");

  // A saturated hue has one full channel, unless the pixel is black.
  a_full_chan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (red_r == CH_FULL || green_r == CH_FULL || blue_r == CH_FULL ||
                   (red_r == CH_NONE && green_r == CH_NONE && blue_r == CH_NONE)))
    else $error("pixel has no full channel");
`endif

endmodule
